// ===== src/csp_pkg.sv =====
// Package for the connection slot pool: pool size and codes for mode, status, slot phase, register index and state.
// No dependencies.
package csp_pkg;

   localparam int SLOT_COUNT = 16;

   typedef enum logic [1:0] {
      MODE_ACQUIRE = 2'd0,
      MODE_RELEASE = 2'd1,
      MODE_DISCARD = 2'd2,
      MODE_PRUNE   = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_REUSED    = 3'd0,
      ST_NEW       = 3'd1,
      ST_FULL      = 3'd2,
      ST_TO_IDLE   = 3'd3,
      ST_DROPPED   = 3'd4,
      ST_DISCARDED = 3'd5,
      ST_IGNORED   = 3'd6,
      ST_PRUNED    = 3'd7
   } status_type;

   typedef enum logic [1:0] {
      PH_FREE = 2'd0,
      PH_BUSY = 2'd1,
      PH_IDLE = 2'd2,
      PH_RSVD = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      CSR_MAX_TOTAL = 3'd0,
      CSR_MAX_IDLE  = 3'd1,
      CSR_MAX_REUSE = 3'd2,
      CSR_IDLE_LIM  = 3'd3,
      CSR_LIFE_LIM  = 3'd4
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_REL_RD,
      S_REL_WR,
      S_ACQ_POP,
      S_ACQ_RD,
      S_ACQ_CHK,
      S_ACQ_NEW,
      S_PR_RD,
      S_PR_STK,
      S_PR_CHK,
      S_DONE
   } state_type;

endpackage

// ===== src/connection_slot_pool_unit.sv =====
// Top level of the connection slot pool: sequencer over slot and idle-stack memories.
// Depends on csp_pkg.
//
//  channel | ports                                   | handshake
//  req     | req_mode, req_slot, req_now_ms          | start & !busy
//  rsp     | rsp_status ... rsp_created_count        | rsp_valid, one cycle
//  csr     | csr_we, csr_index, csr_wdata            | csr_we
//
// Release passes through a slot read and a slot write before the result strobe;
// discard and an ignored word end after the slot read. Acquire pops each idle slot
// in turn (stack read, slot read, check) until one is granted; with the stack empty
// it reports the pool full or makes a new slot. Prune reads and checks each idle
// entry in turn. A new item is taken in the cycle after the result strobe. Reset is
// synchronous; slot memories need none, the phase bits are flip-flops cleared
// by reset. The receiver cannot stall.
module connection_slot_pool_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_mode,
   input  logic [3:0]  req_slot,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_granted_slot,
   output logic [31:0] rsp_conn_id,
   output logic [15:0] rsp_uses_so_far,
   output logic [4:0]  rsp_idle_count,
   output logic [4:0]  rsp_busy_count,
   output logic [31:0] rsp_created_count,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import csp_pkg::*;

   localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CW = $clog2(SLOT_COUNT + 1);

   // configuration
   logic [4:0]  max_total_ff, max_idle_ff;
   logic [15:0] max_reuse_ff;
   logic [31:0] idle_lim_ff, life_lim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_total_ff <= 5'd16;
         max_idle_ff  <= 5'd8;
         max_reuse_ff <= 16'd100;
         idle_lim_ff  <= 32'd30000;
         life_lim_ff  <= 32'd300000;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAX_TOTAL: max_total_ff <= csr_wdata[4:0];
            CSR_MAX_IDLE:  max_idle_ff  <= csr_wdata[4:0];
            CSR_MAX_REUSE: max_reuse_ff <= csr_wdata[15:0];
            CSR_IDLE_LIM:  idle_lim_ff  <= csr_wdata;
            CSR_LIFE_LIM:  life_lim_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // slot memory word: reuses, born, touched, ident
   typedef struct packed {
      logic [15:0] reuses;
      logic [31:0] born;
      logic [31:0] touched;
      logic [31:0] ident;
   } slot_word_type;

   slot_word_type slot_mem [SLOT_COUNT];
   logic [AW-1:0] stack_mem [SLOT_COUNT];

   slot_word_type slot_rd_ff;
   logic [AW-1:0] stack_rd_ff;

   logic          slot_we, stack_we;
   logic [AW-1:0] slot_addr, stack_raddr, stack_waddr, stack_wdata;
   slot_word_type slot_wdata;

   always_ff @(posedge clock) begin
      if (slot_we) slot_mem[slot_addr] <= slot_wdata;
      slot_rd_ff <= slot_mem[slot_addr];
   end

   always_ff @(posedge clock) begin
      if (stack_we) stack_mem[stack_waddr] <= stack_wdata;
      stack_rd_ff <= stack_mem[stack_raddr];
   end

   // control registers
   state_type       state_ff, state_in;
   phase_type       phase_ff [SLOT_COUNT];
   logic [CW-1:0]   idle_depth_ff, idle_depth_in;
   logic [CW-1:0]   busy_total_ff, busy_total_in;
   logic [31:0]     next_ident_ff, next_ident_in;
   logic [CW-1:0]   idx_ff, idx_in, kept_ff, kept_in;
   logic [AW-1:0]   cur_ff, cur_in;
   logic [1:0]      mode_ff;
   logic [3:0]      slot_req_ff;
   logic [31:0]     now_ff;
   logic [2:0]      status_ff, status_in;
   logic [3:0]      gslot_ff, gslot_in;
   logic [31:0]     conn_ff, conn_in;
   logic [15:0]     uses_ff, uses_in;
   logic            ph_we;
   logic [AW-1:0]   ph_addr;
   phase_type       ph_val;

   // lowest free slot
   logic          free_found;
   logic [AW-1:0] free_idx;
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (phase_ff[i] == PH_FREE) begin
            free_found = 1'b1;
            free_idx   = AW'(i);
         end
      end
   end

   // reuse test on the word just read
   slot_word_type chk_word;
   logic          reusable;
   always_comb begin
      reusable = (chk_word.reuses < max_reuse_ff) &&
                 ((now_ff - chk_word.born) < life_lim_ff) &&
                 ((now_ff - chk_word.touched) < idle_lim_ff);
   end

   logic          req_in_range, req_is_busy;
   logic [15:0]   inc_reuses;
   assign req_in_range = ({4'd0, slot_req_ff} < 8'(SLOT_COUNT));
   assign req_is_busy  = req_in_range && (phase_ff[slot_req_ff[AW-1:0]] == PH_BUSY);
   assign inc_reuses   = (slot_rd_ff.reuses != 16'hFFFF) ? slot_rd_ff.reuses + 16'd1
                                                         : slot_rd_ff.reuses;

   // next state and datapath
   always_comb begin
      state_in      = state_ff;
      idle_depth_in = idle_depth_ff;
      busy_total_in = busy_total_ff;
      next_ident_in = next_ident_ff;
      idx_in        = idx_ff;
      kept_in       = kept_ff;
      cur_in        = cur_ff;
      status_in     = status_ff;
      gslot_in      = gslot_ff;
      conn_in       = conn_ff;
      uses_in       = uses_ff;
      slot_we       = 1'b0;
      slot_addr     = slot_req_ff[AW-1:0];
      slot_wdata    = slot_rd_ff;
      stack_we      = 1'b0;
      stack_raddr   = '0;
      stack_waddr   = '0;
      stack_wdata   = '0;
      ph_we         = 1'b0;
      ph_addr       = '0;
      ph_val        = PH_FREE;
      chk_word      = slot_rd_ff;
      case (state_ff)
         S_IDLE: begin
            slot_addr = req_slot[AW-1:0];
            if (start) begin
               status_in = ST_IGNORED;
               gslot_in  = '0;
               conn_in   = '0;
               uses_in   = '0;
               idx_in    = '0;
               kept_in   = '0;
               case (mode_type'(req_mode))
                  MODE_ACQUIRE: state_in = S_ACQ_POP;
                  MODE_PRUNE:   state_in = S_PR_STK;
                  default:      state_in = S_REL_RD;
               endcase
            end
         end
         S_REL_RD: begin
            // read of the slot word has landed
            if (!req_is_busy) begin
               state_in = S_DONE;
            end else if (mode_ff == MODE_DISCARD) begin
               busy_total_in = busy_total_ff - CW'(1);
               ph_we = 1'b1; ph_addr = slot_req_ff[AW-1:0]; ph_val = PH_FREE;
               status_in = ST_DISCARDED;
               state_in = S_DONE;
            end else begin
               state_in = S_REL_WR;
            end
         end
         S_REL_WR: begin
            chk_word.reuses  = inc_reuses;
            chk_word.touched = now_ff;
            slot_we    = 1'b1;
            slot_wdata = chk_word;
            busy_total_in = busy_total_ff - CW'(1);
            uses_in = inc_reuses;
            ph_we = 1'b1; ph_addr = slot_req_ff[AW-1:0];
            if (reusable && (8'(idle_depth_ff) < 8'(max_idle_ff))
                  && (8'(idle_depth_ff) < 8'(SLOT_COUNT))) begin
               stack_we = 1'b1;
               stack_waddr = idle_depth_ff[AW-1:0];
               stack_wdata = slot_req_ff[AW-1:0];
               idle_depth_in = idle_depth_ff + CW'(1);
               ph_val = PH_IDLE;
               status_in = ST_TO_IDLE;
            end else begin
               ph_val = PH_FREE;
               status_in = ST_DROPPED;
            end
            state_in = S_DONE;
         end
         S_ACQ_POP: begin
            if (idle_depth_ff != '0) begin
               stack_raddr   = AW'(idle_depth_ff - CW'(1));
               idle_depth_in = idle_depth_ff - CW'(1);
               state_in      = S_ACQ_RD;
            end else if (8'(busy_total_ff) >= 8'(max_total_ff) || !free_found) begin
               status_in = ST_FULL;
               state_in  = S_DONE;
            end else begin
               cur_in   = free_idx;
               state_in = S_ACQ_NEW;
            end
         end
         S_ACQ_RD: begin
            cur_in    = stack_rd_ff;
            slot_addr = stack_rd_ff;
            state_in  = S_ACQ_CHK;
         end
         S_ACQ_CHK: begin
            slot_addr = cur_ff;
            ph_we = 1'b1; ph_addr = cur_ff;
            if (reusable) begin
               ph_val = PH_BUSY;
               slot_we = 1'b1;
               slot_wdata.touched = now_ff;
               busy_total_in = busy_total_ff + CW'(1);
               status_in = ST_REUSED;
               gslot_in  = 4'(cur_ff);
               conn_in   = slot_rd_ff.ident;
               uses_in   = slot_rd_ff.reuses;
               state_in  = S_DONE;
            end else begin
               ph_val   = PH_FREE;
               state_in = S_ACQ_POP;
            end
         end
         S_ACQ_NEW: begin
            slot_addr = cur_ff;
            slot_we = 1'b1;
            slot_wdata.reuses  = '0;
            slot_wdata.born    = now_ff;
            slot_wdata.touched = now_ff;
            slot_wdata.ident   = next_ident_ff;
            ph_we = 1'b1; ph_addr = cur_ff; ph_val = PH_BUSY;
            next_ident_in = next_ident_ff + 32'd1;
            busy_total_in = busy_total_ff + CW'(1);
            status_in = ST_NEW;
            gslot_in  = 4'(cur_ff);
            conn_in   = next_ident_ff;
            state_in  = S_DONE;
         end
         S_PR_STK: begin
            // read stack entry idx
            if (idx_ff < idle_depth_ff) begin
               stack_raddr = idx_ff[AW-1:0];
               state_in = S_PR_RD;
            end else begin
               idle_depth_in = kept_ff;
               status_in = ST_PRUNED;
               state_in = S_DONE;
            end
         end
         S_PR_RD: begin
            cur_in    = stack_rd_ff;
            slot_addr = stack_rd_ff;
            state_in  = S_PR_CHK;
         end
         S_PR_CHK: begin
            slot_addr = cur_ff;
            if (reusable) begin
               stack_we = 1'b1;
               stack_waddr = kept_ff[AW-1:0];
               stack_wdata = cur_ff;
               kept_in = kept_ff + CW'(1);
            end else begin
               ph_we = 1'b1; ph_addr = cur_ff; ph_val = PH_FREE;
            end
            idx_in   = idx_ff + CW'(1);
            state_in = S_PR_STK;
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         idle_depth_ff <= '0;
         busy_total_ff <= '0;
         next_ident_ff <= 32'd1;
         for (int i = 0; i < SLOT_COUNT; i++) phase_ff[i] <= PH_FREE;
      end else begin
         state_ff      <= state_in;
         idle_depth_ff <= idle_depth_in;
         busy_total_ff <= busy_total_in;
         next_ident_ff <= next_ident_in;
         if (ph_we) phase_ff[ph_addr] <= ph_val;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      kept_ff   <= kept_in;
      cur_ff    <= cur_in;
      status_ff <= status_in;
      gslot_ff  <= gslot_in;
      conn_ff   <= conn_in;
      uses_ff   <= uses_in;
      if (state_ff == S_IDLE && start) begin
         mode_ff     <= req_mode;
         slot_req_ff <= req_slot;
         now_ff      <= req_now_ms;
      end
   end

   // outputs
   assign busy              = (state_ff != S_IDLE);
   assign rsp_valid         = (state_ff == S_DONE);
   assign rsp_status        = status_ff;
   assign rsp_granted_slot  = gslot_ff;
   assign rsp_conn_id       = conn_ff;
   assign rsp_uses_so_far   = uses_ff;
   assign rsp_idle_count    = 5'(idle_depth_ff);
   assign rsp_busy_count    = 5'(busy_total_ff);
   assign rsp_created_count = next_ident_ff - 32'd1;

endmodule

// ===== src/csp_checker.sv =====
// Port-level checker for connection_slot_pool_unit, bound to the top level.
// Depends on csp_pkg.
module csp_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [2:0]  rsp_status,
   input logic [3:0]  rsp_granted_slot,
   input logic [31:0] rsp_conn_id,
   input logic [4:0]  rsp_idle_count,
   input logic [31:0] rsp_created_count
);
   import csp_pkg::*;

   // an accepted word always makes the block busy
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accept did not raise busy");

   // a result strobe ends the busy period
   a_rsp_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy) else $error("busy after result");

   // only grants carry a slot or identity
   a_grant_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_REUSED && rsp_status != ST_NEW)
      |-> (rsp_granted_slot == 4'd0 && rsp_conn_id == 32'd0))
      else $error("non-grant carries slot data");

   // a new connection carries the identity equal to the created count
   a_created: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_NEW) |-> (rsp_conn_id == rsp_created_count))
      else $error("new identity mismatch");

   // idle depth never exceeds the pool size
   a_idle_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_idle_count <= 5'd16)) else $error("idle count too large");

endmodule

bind connection_slot_pool_unit csp_checker u_csp_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_status(rsp_status),
   .rsp_granted_slot(rsp_granted_slot), .rsp_conn_id(rsp_conn_id),
   .rsp_idle_count(rsp_idle_count), .rsp_created_count(rsp_created_count)
);

// ===== test/connection_slot_pool_checker.sv =====
// Checker for the connection slot pool: watches request, result and register ports,
// predicts each result word and compares it. Depends on csp_pkg.
module connection_slot_pool_checker
   import csp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_mode,
   input  logic [3:0]  req_slot,
   input  logic [31:0] req_now_ms,
   input  logic        rsp_valid,
   input  logic [2:0]  rsp_status,
   input  logic [3:0]  rsp_granted_slot,
   input  logic [31:0] rsp_conn_id,
   input  logic [15:0] rsp_uses_so_far,
   input  logic [4:0]  rsp_idle_count,
   input  logic [4:0]  rsp_busy_count,
   input  logic [31:0] rsp_created_count,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output int          outstanding,
   output int          errors
);

   typedef struct packed {
      status_type  status;
      logic [3:0]  slot;
      logic [31:0] conn_id;
      logic [15:0] uses;
      logic [4:0]  idle_cnt;
      logic [4:0]  busy_cnt;
      logic [31:0] created;
   } pool_word_type;

   // pool settings
   logic [4:0]  lim_total, lim_idle;
   logic [15:0] lim_reuse;
   logic [31:0] lim_idle_ms, lim_life_ms;

   // pool state
   phase_type   phase[16];
   logic [15:0] reuses[16];
   logic [31:0] born[16], touched[16], ident[16];
   logic [3:0]  stack[16];
   int          depth, busy_num;
   logic [31:0] next_id;

   pool_word_type pending_words[$];

   assign outstanding = pending_words.size();

   function automatic bit reusable(logic [3:0] s, logic [31:0] now);
      logic [31:0] age, rest;
      age = now - born[s];
      rest = now - touched[s];
      return reuses[s] < lim_reuse && age < lim_life_ms && rest < lim_idle_ms;
   endfunction

   // advance the pool by one request word and return what it answers
   function automatic pool_word_type pool_step(mode_type m, logic [3:0] s, logic [31:0] now);
      pool_word_type w;
      logic [3:0] p;
      int         kept;
      bit         done;
      w = '0;
      done = 0;
      case (m)
         MODE_ACQUIRE: begin
            while (depth > 0 && !done) begin
               depth--;
               p = stack[depth];
               if (reusable(p, now)) begin
                  phase[p] = PH_BUSY;
                  touched[p] = now;
                  busy_num++;
                  w.status = ST_REUSED;
                  w.slot = p;
                  w.conn_id = ident[p];
                  w.uses = reuses[p];
                  done = 1;
               end else begin
                  phase[p] = PH_FREE;
               end
            end
            if (!done) begin
               w.status = ST_FULL;
               if (busy_num + depth < int'(lim_total)) begin
                  for (int i = 15; i >= 0; i--)
                     if (phase[i] == PH_FREE) begin
                        p = 4'(i);
                        done = 1;
                     end
                  if (done) begin
                     phase[p] = PH_BUSY;
                     ident[p] = next_id;
                     next_id++;
                     reuses[p] = '0;
                     born[p] = now;
                     touched[p] = now;
                     busy_num++;
                     w.status = ST_NEW;
                     w.slot = p;
                     w.conn_id = ident[p];
                  end
               end
            end
         end
         MODE_RELEASE: begin
            if (phase[s] != PH_BUSY) begin
               w.status = ST_IGNORED;
            end else begin
               busy_num--;
               if (reuses[s] != 16'hFFFF) reuses[s]++;
               touched[s] = now;
               w.uses = reuses[s];
               if (reusable(s, now) && depth < int'(lim_idle) && depth < 16) begin
                  stack[depth] = s;
                  depth++;
                  phase[s] = PH_IDLE;
                  w.status = ST_TO_IDLE;
               end else begin
                  phase[s] = PH_FREE;
                  w.status = ST_DROPPED;
               end
            end
         end
         MODE_DISCARD: begin
            if (phase[s] != PH_BUSY) begin
               w.status = ST_IGNORED;
            end else begin
               busy_num--;
               phase[s] = PH_FREE;
               w.status = ST_DISCARDED;
            end
         end
         default: begin
            // keep fresh entries in their order, free the stale ones
            kept = 0;
            for (int i = 0; i < depth; i++) begin
               p = stack[i];
               if (reusable(p, now)) begin
                  stack[kept] = p;
                  kept++;
               end else begin
                  phase[p] = PH_FREE;
               end
            end
            depth = kept;
            w.status = ST_PRUNED;
         end
      endcase
      w.idle_cnt = 5'(depth);
      w.busy_cnt = 5'(busy_num);
      w.created = next_id - 1;
      return w;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      pool_word_type w;
      if (reset) begin
         lim_total <= 5'd16;
         lim_idle <= 5'd8;
         lim_reuse <= 16'd100;
         lim_idle_ms <= 32'd30000;
         lim_life_ms <= 32'd300000;
         for (int i = 0; i < 16; i++) phase[i] = PH_FREE;
         depth = 0;
         busy_num = 0;
         next_id = 32'd1;
         pending_words = {};
      end else begin
         // compare the result word with the oldest expectation
         if (rsp_valid) begin
            if (pending_words.size() == 0) begin
               report("unexpected result, status", 32'(rsp_status), 32'hx);
            end else begin
               w = pending_words.pop_front();
               if (rsp_status !== w.status) report("status", 32'(rsp_status), 32'(w.status));
               if (rsp_granted_slot !== w.slot)
                  report("granted_slot", 32'(rsp_granted_slot), 32'(w.slot));
               if (rsp_conn_id !== w.conn_id) report("conn_id", rsp_conn_id, w.conn_id);
               if (rsp_uses_so_far !== w.uses)
                  report("uses_so_far", 32'(rsp_uses_so_far), 32'(w.uses));
               if (rsp_idle_count !== w.idle_cnt)
                  report("idle_count", 32'(rsp_idle_count), 32'(w.idle_cnt));
               if (rsp_busy_count !== w.busy_cnt)
                  report("busy_count", 32'(rsp_busy_count), 32'(w.busy_cnt));
               if (rsp_created_count !== w.created)
                  report("created_count", rsp_created_count, w.created);
            end
         end
         // predict each accepted request word
         if (start && !busy)
            pending_words = {pending_words,
                             pool_step(mode_type'(req_mode), req_slot, req_now_ms)};
         // track register writes
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_MAX_TOTAL: lim_total <= csr_wdata[4:0];
               CSR_MAX_IDLE:  lim_idle <= csr_wdata[4:0];
               CSR_MAX_REUSE: lim_reuse <= csr_wdata[15:0];
               CSR_IDLE_LIM:  lim_idle_ms <= csr_wdata;
               CSR_LIFE_LIM:  lim_life_ms <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   initial errors = 0;

endmodule

// ===== test/testbench.sv =====
// Top of the connection slot pool test: clock, reset, register settings and request
// stimulus. Depends on csp_pkg, connection_slot_pool_unit and connection_slot_pool_checker.
module testbench;
   import csp_pkg::*;

   logic        clock, reset, start, busy;
   logic [1:0]  req_mode;
   logic [3:0]  req_slot;
   logic [31:0] req_now_ms;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [3:0]  rsp_granted_slot;
   logic [31:0] rsp_conn_id;
   logic [15:0] rsp_uses_so_far;
   logic [4:0]  rsp_idle_count, rsp_busy_count;
   logic [31:0] rsp_created_count;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;
   int          outstanding, errors;
   int          cycles;
   int          gap_pct;
   logic [31:0] clock_ms;
   logic [3:0]  held_slots[$];

   connection_slot_pool_unit i_dut (.*);
   connection_slot_pool_checker i_checker (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // stop a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 600000) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   // remember granted slots so releases mostly hit busy ones
   always @(posedge clock)
      if (!reset && rsp_valid && (rsp_status == ST_REUSED || rsp_status == ST_NEW))
         held_slots = {held_slots, rsp_granted_slot};

   // hand one word to the block and hold until it is taken
   task automatic send_word(mode_type m, logic [3:0] s, logic [31:0] now);
      start <= 1'b1;
      req_mode <= m;
      req_slot <= s;
      req_now_ms <= now;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < gap_pct) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0 || busy) @(posedge clock);
   endtask

   task automatic write_regs(logic [4:0] total, logic [4:0] idle, logic [15:0] reuse,
                             logic [31:0] idle_ms, logic [31:0] life_ms);
      logic [31:0] vals[5];
      vals = '{32'(total), 32'(idle), 32'(reuse), idle_ms, life_ms};
      wait_drained();
      for (int i = 0; i < 5; i++) begin
         csr_we <= 1'b1;
         csr_index <= 3'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // random word; releases and discards mostly pick held slots
   task automatic random_word(int span);
      int         pick, k;
      logic [3:0] s;
      if ($urandom_range(99) < 2) clock_ms = clock_ms + $urandom;
      else clock_ms = clock_ms + $urandom_range(span);
      pick = $urandom_range(99);
      s = 4'($urandom_range(15));
      if ((pick >= 40 && pick < 90) && held_slots.size() > 0 && $urandom_range(9) != 0) begin
         k = $urandom_range(held_slots.size() - 1);
         s = held_slots[k];
         held_slots.delete(k);
      end
      if (pick < 40) send_word(MODE_ACQUIRE, s, clock_ms);
      else if (pick < 78) send_word(MODE_RELEASE, s, clock_ms);
      else if (pick < 90) send_word(MODE_DISCARD, s, clock_ms);
      else send_word(MODE_PRUNE, s, clock_ms);
   endtask

   initial begin
      int gaps[5];
      int spans[5];
      gaps = '{0, 83, 0, 10, 83};
      spans = '{2000, 2, 1000, 30, 200};
      cycles = 0;
      gap_pct = 0;
      reset <= 1'b1;
      start <= 1'b0;
      req_mode <= MODE_ACQUIRE;
      req_slot <= '0;
      req_now_ms <= '0;
      csr_we <= 1'b0;
      csr_index <= CSR_MAX_TOTAL;
      csr_wdata <= '0;
      clock_ms = $urandom;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill the pool past its limit, park and drop, then age everything out
      for (int i = 0; i < 17; i++) send_word(MODE_ACQUIRE, 4'd0, clock_ms + 32'(i));
      clock_ms = clock_ms + 100;
      for (int i = 0; i < 3; i++) send_word(MODE_RELEASE, 4'(i), clock_ms);
      send_word(MODE_RELEASE, 4'd0, clock_ms);
      send_word(MODE_DISCARD, 4'd15, clock_ms);
      send_word(MODE_DISCARD, 4'd15, clock_ms);
      send_word(MODE_ACQUIRE, 4'd9, clock_ms + 5);
      send_word(MODE_PRUNE, 4'd3, clock_ms + 32'd40000);
      send_word(MODE_ACQUIRE, 4'd0, clock_ms + 32'd40000);
      // hold off until every result is back
      wait_drained();
      held_slots = {};
      for (int i = 3; i < 15; i++) held_slots = {held_slots, 4'(i)};
      clock_ms = clock_ms + 32'd40000;

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            1: write_regs(5'd1, 5'd1, 16'd1, 32'd1, 32'd1);
            2: write_regs(5'd16, 5'd16, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            3: write_regs(5'd6, 5'd3, 16'd4, 32'd60, 32'd250);
            4: write_regs(5'd12, 5'd5, 16'd20, 32'd500, 32'd3000);
            default: ;
         endcase
         gap_pct = gaps[ph];
         for (int n = 0; n < 230; n++) begin
            // leave some stretches without idling
            if (n % 60 == 0) gap_pct = (gap_pct == 0) ? gaps[ph] : 0;
            if (n % 60 == 20) gap_pct = gaps[ph];
            random_word(spans[ph]);
         end
      end

      wait_drained();
      repeat (60) @(posedge clock);
      if (errors == 0 && outstanding == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
